// File: sv/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg: shared types for the vertex deduplication indexer
// Vertex, probe and transfer payload types used by the chain cells and the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

package vdi_pkg;

    // Width of the reported vertex index.
    localparam int VIDX_W = 10;

    // Corner position of the last vertex of a triangle.
    localparam logic [1:0] CORNER_LAST = 2'd2;
    localparam logic [1:0] CORNER_FIRST = 2'd0;

    // One vertex as three single-precision bit patterns.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_vertex;

    // Input transfer payload.
    typedef struct packed {
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
        logic        mesh_end;
    } t_in_item;

    // Output transfer payload.
    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        logic              is_new;
        logic              table_full;
        logic [1:0]        corner;
        logic              incomplete_triangle;
        logic              mesh_done;
    } t_out_item;

    // A lookup travelling down the cell chain.
    typedef struct packed {
        logic       valid;
        logic       mesh_end;
        logic       found;
        logic       is_new;
        logic [1:0] corner;
        logic       incomplete;
        t_vertex    vtx;
    } t_probe;

endpackage

`default_nettype wire

// File: sv/vdi_cell.sv
// ----------------------------------------------------------------------------
// vdi_cell: one table entry of the deduplication chain
// Holds one unique vertex, compares the passing probe with it, claims the
// entry for an unmatched probe when empty, and forwards the probe one cell
// per cycle while i_advance is high. A probe ending a mesh empties the entry.
// ----------------------------------------------------------------------------
`default_nettype none

module vdi_cell #(
    parameter int TABLE_DEPTH = 1024,
    parameter int CELL_INDEX  = 0
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_advance,
    input  wire  vdi_pkg::t_probe             i_probe,
    input  wire  [$clog2(TABLE_DEPTH)-1:0]    i_idx,
    output vdi_pkg::t_probe                   o_probe,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_idx
);

    import vdi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic           r_vld;
    t_vertex        r_vtx;
    t_probe         r_probe;
    logic [IDX_W-1:0] r_idx;

    logic           hit;
    logic           claim;
    t_probe         n_probe;
    logic [IDX_W-1:0] n_idx;

    // Match against the stored vertex, or claim the first empty entry.
    always_comb begin
        hit   = i_probe.valid && !i_probe.found && r_vld && (r_vtx == i_probe.vtx);
        claim = i_probe.valid && !i_probe.found && !r_vld;
        n_probe        = i_probe;
        n_probe.found  = i_probe.found | hit | claim;
        n_probe.is_new = i_probe.is_new | claim;
        n_idx          = (hit || claim) ? MY_IDX : i_idx;
    end

    // Entry state: filled by a claim, emptied when a mesh ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_advance && i_probe.valid) begin
            if (i_probe.mesh_end) begin
                r_vld <= 1'b0;
            end else if (claim) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && claim) begin
            r_vtx <= i_probe.vtx;
        end
    end

    // Probe register toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else if (i_advance) begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_idx <= n_idx;
        end
    end

    assign o_probe = r_probe;
    assign o_idx   = r_idx;

endmodule

`default_nettype wire

// File: sv/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer: vertex deduplication for an index buffer
// Turns a triangle-soup vertex stream into indices of unique vertices.
// ----------------------------------------------------------------------------
// The table is a chain of TABLE_DEPTH cells, one per unique vertex. Each
// accepted vertex (signed zeros folded to +0) walks the chain one cell per
// cycle while the chain advances: the first cell holding an equal vertex
// supplies its index, and an unmatched vertex is stored in the first empty
// cell and flagged new. A vertex that finds neither is reported with
// table_full set and index 0. The vertex that carries mesh_end empties every
// cell as it passes, so the next mesh starts with an empty table. A new
// vertex is taken every cycle while the chain advances; each result passes
// the cell registers and then the output register. When the output is
// stalled, the chain keeps moving as long as its last cell holds no vertex.
`default_nettype none

module vertex_dedup_indexer #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire vdi_pkg::t_in_item i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output vdi_pkg::t_out_item   o_out_data
);

    import vdi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    t_probe           probe [0:TABLE_DEPTH];
    logic [IDX_W-1:0] idx   [0:TABLE_DEPTH];

    logic             advance;
    logic             out_load;
    logic [1:0]       r_corner;
    logic [1:0]       n_corner;
    logic [1:0]       corner;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic [IDX_W+VIDX_W-1:0] idx_wide;

    // Whole chain moves unless a held result would be overwritten.
    assign advance  = !(r_out_valid && i_out_stall && probe[TABLE_DEPTH].valid);
    assign out_load = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;

    // Corner tracking and the probe that enters the chain.
    always_comb begin
        corner = (r_corner > CORNER_LAST) ? CORNER_FIRST : r_corner;
        if (i_in_data.mesh_end || corner == CORNER_LAST) begin
            n_corner = CORNER_FIRST;
        end else begin
            n_corner = corner + 2'd1;
        end
        probe[0].valid      = i_in_valid;
        probe[0].mesh_end   = i_in_data.mesh_end;
        probe[0].found      = 1'b0;
        probe[0].is_new     = 1'b0;
        probe[0].corner     = corner;
        probe[0].incomplete = i_in_data.mesh_end && (corner != CORNER_LAST);
        probe[0].vtx.x = (i_in_data.coord_x[30:0] == '0) ? '0 : i_in_data.coord_x;
        probe[0].vtx.y = (i_in_data.coord_y[30:0] == '0) ? '0 : i_in_data.coord_y;
        probe[0].vtx.z = (i_in_data.coord_z[30:0] == '0) ? '0 : i_in_data.coord_z;
        idx[0] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= CORNER_FIRST;
        end else if (i_in_valid && advance) begin
            r_corner <= n_corner;
        end
    end

    // Chain of table cells.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        vdi_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_INDEX  (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_probe   (probe[g]),
            .i_idx     (idx[g]),
            .o_probe   (probe[g+1]),
            .o_idx     (idx[g+1])
        );
    end

    // Result formatting from the probe leaving the chain.
    always_comb begin
        idx_wide = {{VIDX_W{1'b0}}, idx[TABLE_DEPTH]};
        n_out.vertex_index        = idx_wide[VIDX_W-1:0];
        n_out.is_new              = probe[TABLE_DEPTH].is_new;
        n_out.table_full          = !probe[TABLE_DEPTH].found;
        n_out.corner              = probe[TABLE_DEPTH].corner;
        n_out.incomplete_triangle = probe[TABLE_DEPTH].incomplete;
        n_out.mesh_done           = probe[TABLE_DEPTH].mesh_end;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= probe[TABLE_DEPTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: vertex deduplication indexer
// Streams directed and random triangle meshes through the indexer and checks
// every result against a behavioral lookup table kept alongside the stream.
// ----------------------------------------------------------------------------

module testbench;
    import vdi_pkg::*;

    localparam int          TABLE_DEPTH  = 1024;
    localparam int          CLK_PERIOD   = 20;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_ITEMS = 250;
    localparam int          DRAIN_CYCLES = TABLE_DEPTH + 16;
    localparam int          IDLE_LIMIT   = 8000;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

    // Clock, reset and both channels.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Shadow of the vertex table and the triangle position.
    t_vertex     vertex_table [TABLE_DEPTH];
    int unsigned table_entries = 0;
    logic [1:0]  next_corner   = CORNER_FIRST;
    t_out_item   pending_results [$];

    // Idling controls and run statistics.
    bit gaps_on     = 1'b1;
    bit stall_on    = 1'b1;
    int stall_burst = 0;
    int idle_cycles = 0;
    int errors      = 0;
    int items_sent  = 0;
    int results_seen = 0;
    int new_seen    = 0;
    int reused_seen = 0;
    int full_seen   = 0;
    int early_seen  = 0;
    int meshes_seen = 0;

    vertex_dedup_indexer #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Both signed zeros compare and store as +0.
    function automatic logic [31:0] fold_signed_zero(input logic [31:0] w);
        return (w[30:0] == 31'd0) ? 32'd0 : w;
    endfunction

    // Looks the vertex up in the shadow table and advances the mesh state.
    function automatic t_out_item index_vertex(input t_in_item item);
        t_vertex     v;
        t_out_item   r;
        logic        hit;
        int unsigned k;
        v.x = fold_signed_zero(item.coord_x);
        v.y = fold_signed_zero(item.coord_y);
        v.z = fold_signed_zero(item.coord_z);
        r = '0;
        hit = 1'b0;
        for (k = 0; k < table_entries && !hit; k++) begin
            if (vertex_table[k] == v) begin
                hit = 1'b1;
                r.vertex_index = VIDX_W'(k);
            end
        end
        if (!hit) begin
            if (table_entries < TABLE_DEPTH) begin
                vertex_table[table_entries] = v;
                r.vertex_index = VIDX_W'(table_entries);
                r.is_new = 1'b1;
                table_entries++;
            end else begin
                r.table_full = 1'b1;
            end
        end
        r.corner = next_corner;
        r.incomplete_triangle = item.mesh_end && (next_corner != CORNER_LAST);
        r.mesh_done = item.mesh_end;
        if (item.mesh_end) begin
            table_entries = 0;
            next_corner = CORNER_FIRST;
        end else begin
            next_corner = (next_corner == CORNER_LAST) ? CORNER_FIRST : next_corner + 2'd1;
        end
        return r;
    endfunction

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coordinates lean toward zeros and special float patterns.
    function automatic logic [31:0] random_coord();
        logic [31:0] specials [8];
        specials = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h3F80_0000};
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return SIGN_BIT;
            2: return specials[$urandom_range(0, 7)];
            default: return $urandom;
        endcase
    endfunction

    // A zero coordinate may come back with the other sign.
    function automatic logic [31:0] flip_zero_sign(input logic [31:0] w);
        if (w[30:0] == 31'd0 && $urandom_range(0, 1) == 1) return w ^ SIGN_BIT;
        return w;
    endfunction

    // Sends one vertex and records its expected result on acceptance.
    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic last);
        t_in_item item;
        int       gap;
        item.coord_x  = x;
        item.coord_y  = y;
        item.coord_z  = z;
        item.mesh_end = last;
        gap = sender_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (o_in_stall !== 1'b0) @(posedge clk);
        pending_results.insert(pending_results.size(), index_vertex(item));
        items_sent++;
    endtask

    // Three triangles that share corners, closed on a full triangle.
    task automatic test_shared_corners();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        send_vertex(32'h3F80_0000, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0, 32'h3F80_0000, 32'h0, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h3F80_0000, 1'b0);
        send_vertex(32'h3F80_0000, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h3F80_0000, 1'b0);
        send_vertex(32'hBF80_0000, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0, 32'h3F80_0000, 32'h0, 1'b0);
        send_vertex(32'hBF80_0000, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h3F80_0000, 32'h0, 32'h0, 1'b1);
    endtask

    // Signed zeros match each other; extreme and NaN patterns match only themselves.
    task automatic test_signed_zero_and_extremes();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
        send_vertex(SIGN_BIT, SIGN_BIT, SIGN_BIT, 1'b0);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h8000_0001, SIGN_BIT, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0001, 32'h0, 32'h7FFF_FFFF, 1'b1);
    endtask

    // Meshes that end on the first and second corner, then on the third.
    task automatic test_early_mesh_end();
        send_vertex(32'h7FC0_0000, 32'h1, 32'h2, 1'b1);
        send_vertex(32'h7FC0_0000, 32'h1, 32'h2, 1'b0);
        send_vertex(32'h7FC0_0000, 32'h1, 32'h2, 1'b1);
        send_vertex(32'h4000_0000, 32'h0, SIGN_BIT, 1'b0);
        send_vertex(32'h4000_0000, SIGN_BIT, 32'h0, 1'b0);
        send_vertex(32'hC000_0000, 32'h0, 32'h0, 1'b1);
    endtask

    // Fills every entry, then misses, hits at both ends, and a miss that ends the mesh.
    task automatic test_table_full();
        int unsigned k;
        logic [31:0] top;
        top = 32'(TABLE_DEPTH - 1);
        for (k = 0; k < TABLE_DEPTH; k++) begin
            send_vertex(k, k ^ 32'h5A5A_0000, ~k, 1'b0);
        end
        for (k = 0; k < 3; k++) begin
            send_vertex(32'h4000_0000 + k, 32'h1, 32'h2, 1'b0);
        end
        send_vertex(top, top ^ 32'h5A5A_0000, ~top, 1'b0);
        send_vertex(SIGN_BIT, 32'h5A5A_0000, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h4000_0010, 32'h1, 32'h2, 1'b1);
    endtask

    // Random meshes that reuse a pool of vertices, some with ragged ends.
    task automatic test_random_meshes();
        t_vertex pool [$];
        t_vertex v;
        int      mesh_len;
        int      n;
        int      sent;
        int      r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 75) mesh_len = 3 * $urandom_range(1, 15);
            else if (r < 95) mesh_len = $urandom_range(1, 40);
            else mesh_len = $urandom_range(100, 400);
            // The last mesh is cut short so the run keeps its item budget.
            if (mesh_len > RANDOM_ITEMS - sent) mesh_len = RANDOM_ITEMS - sent;
            pool.delete();
            for (n = 0; n < mesh_len; n++) begin
                if (pool.size() != 0 && $urandom_range(0, 99) < 55) begin
                    v = pool[$urandom_range(0, pool.size() - 1)];
                    v.x = flip_zero_sign(v.x);
                    v.y = flip_zero_sign(v.y);
                    v.z = flip_zero_sign(v.z);
                end else begin
                    v.x = random_coord();
                    v.y = random_coord();
                    v.z = random_coord();
                    pool.insert(pool.size(), v);
                end
                send_vertex(v.x, v.y, v.z, n == mesh_len - 1);
            end
            sent += mesh_len;
        end
    endtask

    // Receiver stalls in bursts, mostly short and a few long.
    always @(posedge clk) begin
        if (stall_burst == 0 && stall_on && $urandom_range(0, 99) < 20) begin
            stall_burst = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 50);
        end
        if (stall_burst > 0) begin
            out_stall <= 1'b1;
            stall_burst--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Each output transfer is checked against the oldest expected result.
    always @(posedge clk) begin : check_result
        t_out_item want;
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            results_seen++;
            if (o_out_data.is_new) new_seen++;
            else if (!o_out_data.table_full) reused_seen++;
            if (o_out_data.table_full) full_seen++;
            if (o_out_data.incomplete_triangle) early_seen++;
            if (o_out_data.mesh_done) meshes_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_out_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("vertex_index", want.vertex_index, o_out_data.vertex_index);
                compare_field("is_new", want.is_new, o_out_data.is_new);
                compare_field("table_full", want.table_full, o_out_data.table_full);
                compare_field("corner", want.corner, o_out_data.corner);
                compare_field("incomplete_triangle", want.incomplete_triangle,
                              o_out_data.incomplete_triangle);
                compare_field("mesh_done", want.mesh_done, o_out_data.mesh_done);
            end
        end
    end

    // Ends a run in which no transfer happens on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_shared_corners();
        test_signed_zero_and_extremes();
        test_early_mesh_end();
        test_table_full();
        test_random_meshes();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d vertices in %0d meshes: %0d new, %0d reused, %0d table full.",
                 items_sent, meshes_seen, new_seen, reused_seen, full_seen);
        $display("%0d results checked, %0d meshes closed mid-triangle, %0d errors.",
                 results_seen, early_seen, errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: vertex_dedup_indexer.f
sv/vdi_pkg.sv
sv/vdi_cell.sv
sv/vertex_dedup_indexer.sv
tb/sv/testbench.sv
